/* hdl/bmpg_pkg.sv */
package bmpg_pkg;

	localparam int WINDOW_DEPTH = 512;
	localparam int RAMP_LIMIT = 1023;

	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int LEN_W = ($clog2(WINDOW_DEPTH + 1) > 10) ? $clog2(WINDOW_DEPTH + 1) : 10;
	localparam int CNT_W = 10;
	localparam int SUM_W = 19;
	localparam int TICK_W = 17;
	localparam int SCALE_W = 32;
	localparam int VEL_W = 32;
	localparam int POS_W = 48;
	localparam int PROD_W = SCALE_W + SUM_W + 1;
	localparam int FRAC_SHIFT = 8;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	typedef enum logic [1:0] {
		REG_CRUISE = 2'd0,
		REG_RAMP1  = 2'd1,
		REG_RAMP2  = 2'd2,
		REG_SCALE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]              cruise;
		logic [9:0]               ramp1;
		logic [9:0]               ramp2;
		logic signed [SCALE_W-1:0] scale;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              restart;
		logic [SUM_W-1:0]  sum;
		logic [TICK_W-1:0] tick;
		logic              last;
	} win_item_t;

endpackage

/* hdl/bmpg_window.sv */
module bmpg_window (
	input  logic                clk,
	input  logic                arst_n,
	input  bmpg_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                restart,
	output bmpg_pkg::win_item_t item,
	input  logic                item_ready
);
	import bmpg_pkg::*;

	logic [CNT_W-1:0]  mem [WINDOW_DEPTH];

	logic [CNT_W-1:0]  ramp_q, ramp_base, ramp_next, level;
	logic [CNT_W:0]    ramp_inc;
	logic [PTR_W-1:0]  ptr_q, ptr_base, ptr_next;
	logic [PTR_W:0]    ptr_inc;
	logic [TICK_W-1:0] tick_q, tick_base, tick_next;
	logic [LEN_W-1:0]  len;
	logic [TICK_W:0]   last_sum;
	logic              rising, warm, last_hit;
	logic              accept, take;

	logic              v1_q;
	logic              restart_s1, warm_s1, last_s1;
	logic [CNT_W-1:0]  ramp_s1, rd_s1;
	logic [TICK_W-1:0] tick_s1;

	logic [SUM_W-1:0]  sum_q, sum_base, sum_next, leaving;

	assign take     = v1_q && item_ready;
	assign in_ready = !v1_q || take;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ramp_base = restart ? '0 : ramp_q;
		ptr_base  = restart ? '0 : ptr_q;
		tick_base = restart ? '0 : tick_q;

		level = (32'(cfg.ramp1) > RAMP_LIMIT) ? CNT_W'(RAMP_LIMIT) : cfg.ramp1;
		if (cfg.ramp2 == '0) begin
			len = LEN_W'(1);
		end else if (32'(cfg.ramp2) > WINDOW_DEPTH) begin
			len = LEN_W'(WINDOW_DEPTH);
		end else begin
			len = LEN_W'(cfg.ramp2);
		end

		rising   = 32'(tick_base) <= 32'(cfg.cruise);
		ramp_inc = {1'b0, ramp_base} + 1'b1;
		if (rising) begin
			ramp_next = (ramp_inc > {1'b0, level}) ? level : ramp_inc[CNT_W-1:0];
		end else begin
			ramp_next = (ramp_base == '0) ? '0 : ramp_base - 1'b1;
		end

		ptr_inc  = {1'b0, ptr_base} + 1'b1;
		ptr_next = (32'(ptr_inc) >= 32'(len)) ? '0 : ptr_inc[PTR_W-1:0];

		tick_next = (tick_base == TICK_MAX) ? tick_base : tick_base + 1'b1;
		warm      = 32'(tick_base) < 32'(len);
		last_sum  = (TICK_W+1)'(cfg.cruise) + (TICK_W+1)'(cfg.ramp1) + (TICK_W+1)'(cfg.ramp2);
		last_hit  = {1'b0, tick_base} == last_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q   <= 1'b0;
			ramp_q <= '0;
			ptr_q  <= '0;
			tick_q <= '0;
			sum_q  <= '0;
		end else begin
			if (accept) begin
				v1_q   <= 1'b1;
				ramp_q <= ramp_next;
				ptr_q  <= ptr_next;
				tick_q <= tick_next;
			end else if (take) begin
				v1_q <= 1'b0;
			end
			if (take) begin
				sum_q <= sum_next;
			end
		end
	end

	// Read and write share the accept edge, so the read returns the entry
	// as it was before this transaction overwrites it.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1          <= mem[ptr_base];
			mem[ptr_base]  <= ramp_next;
			ramp_s1        <= ramp_next;
			tick_s1        <= tick_base;
			last_s1        <= last_hit;
			warm_s1        <= warm;
			restart_s1     <= restart;
		end
	end

	always_comb begin
		leaving  = warm_s1 ? '0 : SUM_W'(rd_s1);
		sum_base = restart_s1 ? '0 : sum_q;
		sum_next = sum_base + SUM_W'(ramp_s1) - leaving;
	end

	assign item = '{valid: v1_q, restart: restart_s1, sum: sum_next, tick: tick_s1,
		last: last_s1};

endmodule

/* hdl/bmpg_kin.sv */
module bmpg_kin (
	input  logic                clk,
	input  logic                arst_n,
	input  bmpg_pkg::cfg_t      cfg,
	input  bmpg_pkg::win_item_t item,
	output logic                item_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  velocity,
	output logic signed [47:0]  position_sum,
	output logic signed [32:0]  velocity_change,
	output logic [16:0]         tick_index,
	output logic                last
);
	import bmpg_pkg::*;

	logic                      v2_q, v3_q, out_valid_q;
	logic                      load2, take2, take3;

	logic                      restart_s2, last_s2;
	logic [SUM_W-1:0]          sum_s2;
	logic [TICK_W-1:0]         tick_s2;

	logic                      restart_s3, last_s3;
	logic signed [PROD_W-1:0]  prod_s3;
	logic [TICK_W-1:0]         tick_s3;

	logic [PROD_W-FRAC_SHIFT-1:0] vel_wide;
	logic [VEL_W-1:0]          vel, prior_base;
	logic [VEL_W:0]            change;
	logic [POS_W+1:0]          pos_wide;
	logic [POS_W-1:0]          pos, acc_base;

	logic [VEL_W-1:0]          prior_q;
	logic [POS_W-1:0]          acc_q;

	logic [VEL_W-1:0]          velocity_q;
	logic [POS_W-1:0]          position_q;
	logic [VEL_W:0]            change_q;
	logic [TICK_W-1:0]         tick_q;
	logic                      last_q;

	assign take3      = v3_q && (!out_valid_q || out_ready);
	assign take2      = v2_q && (!v3_q || take3);
	assign item_ready = !v2_q || take2;
	assign load2      = item.valid && item_ready;

	always_comb begin
		vel_wide = prod_s3[PROD_W-1:FRAC_SHIFT];
		if (&vel_wide[PROD_W-FRAC_SHIFT-1:VEL_W-1] || !(|vel_wide[PROD_W-FRAC_SHIFT-1:VEL_W-1])) begin
			vel = vel_wide[VEL_W-1:0];
		end else begin
			vel = vel_wide[PROD_W-FRAC_SHIFT-1] ? {1'b1, {(VEL_W-1){1'b0}}}
				: {1'b0, {(VEL_W-1){1'b1}}};
		end

		prior_base = restart_s3 ? '0 : prior_q;
		acc_base   = restart_s3 ? '0 : acc_q;
		change     = {vel[VEL_W-1], vel} - {prior_base[VEL_W-1], prior_base};
		pos_wide   = {{2{acc_base[POS_W-1]}}, acc_base}
			+ {{(POS_W+2-VEL_W){vel[VEL_W-1]}}, vel}
			+ {{(POS_W+2-VEL_W){prior_base[VEL_W-1]}}, prior_base};
		if (&pos_wide[POS_W+1:POS_W-1] || !(|pos_wide[POS_W+1:POS_W-1])) begin
			pos = pos_wide[POS_W-1:0];
		end else begin
			pos = pos_wide[POS_W+1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
			prior_q     <= '0;
			acc_q       <= '0;
		end else begin
			if (load2) begin
				v2_q <= 1'b1;
			end else if (take2) begin
				v2_q <= 1'b0;
			end
			if (take2) begin
				v3_q <= 1'b1;
			end else if (take3) begin
				v3_q <= 1'b0;
			end
			if (take3) begin
				out_valid_q <= 1'b1;
				prior_q     <= vel;
				acc_q       <= pos;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load2) begin
			sum_s2     <= item.sum;
			tick_s2    <= item.tick;
			last_s2    <= item.last;
			restart_s2 <= item.restart;
		end
		if (take2) begin
			prod_s3    <= $signed(cfg.scale) * $signed({1'b0, sum_s2});
			tick_s3    <= tick_s2;
			last_s3    <= last_s2;
			restart_s3 <= restart_s2;
		end
		if (take3) begin
			velocity_q <= vel;
			position_q <= pos;
			change_q   <= change;
			tick_q     <= tick_s3;
			last_q     <= last_s3;
		end
	end

	assign out_valid       = out_valid_q;
	assign velocity        = velocity_q;
	assign position_sum    = position_q;
	assign velocity_change = change_q;
	assign tick_index      = tick_q;
	assign last            = last_q;

endmodule

/* hdl/boxcar_motion_profile_generator.sv */
// Channel   Handshake              Payload
// input     in_valid / in_ready    restart
// output    out_valid / out_ready  velocity, position_sum, velocity_change, tick_index, last
// config    cfg_we                 cfg_index, cfg_data
//
// One tick is accepted every cycle while in_ready is high; a result passes through the window stage, the sum stage,
// the multiply stage and the output register. The window store is read and written on the accept edge.
// Reset clears the run state and valid flags and sets the config defaults; data registers and the window store are not.
// A stalled output holds the pipeline, and new transactions are taken while bubbles remain.
module boxcar_motion_profile_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] velocity,
	output logic signed [47:0] position_sum,
	output logic signed [32:0] velocity_change,
	output logic [16:0]        tick_index,
	output logic               last,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import bmpg_pkg::*;

	cfg_t      cfg_q;
	win_item_t win_item;
	logic      win_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cruise <= '0;
			cfg_q.ramp1  <= 10'd1;
			cfg_q.ramp2  <= 10'd1;
			cfg_q.scale  <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CRUISE: cfg_q.cruise <= cfg_data[15:0];
				REG_RAMP1:  cfg_q.ramp1  <= cfg_data[9:0];
				REG_RAMP2:  cfg_q.ramp2  <= cfg_data[9:0];
				REG_SCALE:  cfg_q.scale  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bmpg_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.item       (win_item),
		.item_ready (win_ready)
	);

	bmpg_kin u_kin (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.item            (win_item),
		.item_ready      (win_ready),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.velocity        (velocity),
		.position_sum    (position_sum),
		.velocity_change (velocity_change),
		.tick_index      (tick_index),
		.last            (last)
	);

	a_full_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("Input stalled while the pipeline could still advance.");

	a_accept_fills_window_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> win_item.valid)
		else $error("Accepted transaction did not reach the window stage.");

	a_window_stage_held: assert property (@(posedge clk) disable iff (!arst_n)
		win_item.valid && !win_ready |=> win_item.valid && $stable(win_item.tick)
			&& $stable(win_item.sum))
		else $error("Window stage dropped or changed a transaction while stalled.");

endmodule
